// ----- rtl/ephm_pkg.sv -----
`timescale 1ns / 1ps
package ephm_pkg;

  localparam int X_W         = 9;
  localparam int Y_W         = 8;
  localparam int BLOCK_W     = 2;
  localparam int WEIGHT_W    = 4;
  localparam int MASK_W      = 64;
  localparam int THRESHOLD_W = 16;
  localparam int LIMIT_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_LIMIT = 2'd1;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET    = 16'd100;
  localparam logic [LIMIT_W-1:0]     COLUMN_LIMIT_RESET = 8'd185;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_READ,
    ST_EV_WRITE,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic ev_read;
    logic ev_write;
    logic scan_read;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic lane_last;
  } status_t;

endpackage

// ----- rtl/ephm_ctrl.sv -----
`timescale 1ns / 1ps
module ephm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             kind,
  input  ephm_pkg::status_t status,
  output ephm_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  ephm_pkg::state_t state;
  ephm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ephm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ephm_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = ephm_pkg::ST_IDLE;
      end
      ephm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (kind == ephm_pkg::KIND_SCAN) ? ephm_pkg::ST_SCAN
                                                     : ephm_pkg::ST_EV_READ;
        end
      end
      ephm_pkg::ST_EV_READ:    state_next = ephm_pkg::ST_EV_WRITE;
      ephm_pkg::ST_EV_WRITE:   state_next = ephm_pkg::ST_IDLE;
      ephm_pkg::ST_SCAN: begin
        if (status.lane_last) state_next = ephm_pkg::ST_SCAN_DRAIN;
      end
      ephm_pkg::ST_SCAN_DRAIN: state_next = ephm_pkg::ST_RESULT;
      ephm_pkg::ST_RESULT:     state_next = ephm_pkg::ST_IDLE;
      default:                 state_next = ephm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ephm_pkg::ST_CLEAR:      cmd.clear_step = 1'b1;
      ephm_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ephm_pkg::ST_EV_READ:    cmd.ev_read = 1'b1;
      ephm_pkg::ST_EV_WRITE:   cmd.ev_write = 1'b1;
      ephm_pkg::ST_SCAN:       cmd.scan_read = 1'b1;
      ephm_pkg::ST_SCAN_DRAIN: cmd = '0;
      ephm_pkg::ST_RESULT:     done = 1'b1;
      default:                 cmd = '0;
    endcase
  end

endmodule

// ----- rtl/ephm_dp.sv -----
`timescale 1ns / 1ps
module ephm_dp #(
  parameter int SENSOR_WIDTH  = 304,
  parameter int SENSOR_HEIGHT = 240,
  parameter int COUNT_BITS    = 16,
  parameter int SCAN_LANES    = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ephm_pkg::cmd_t                      cmd,
  output ephm_pkg::status_t                   status,
  input  logic [ephm_pkg::X_W-1:0]            x,
  input  logic [ephm_pkg::Y_W-1:0]            y,
  input  logic [ephm_pkg::BLOCK_W-1:0]        y_block,
  input  logic [ephm_pkg::WEIGHT_W-1:0]       weight,
  input  logic                                write_en,
  input  logic [ephm_pkg::CFG_INDEX_W-1:0]    reg_index,
  input  logic [ephm_pkg::CFG_DATA_W-1:0]     write_data,
  output logic [ephm_pkg::X_W-1:0]            row,
  output logic [ephm_pkg::BLOCK_W-1:0]        block,
  output logic [ephm_pkg::MASK_W-1:0]         hot_mask
);

  localparam int DEPTH  = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LANE_W = (SCAN_LANES > 1) ? $clog2(SCAN_LANES) : 1;
  localparam int YY_W   = $clog2(4 * SCAN_LANES);
  localparam int CMP_W  = (COUNT_BITS > ephm_pkg::THRESHOLD_W) ? COUNT_BITS
                                                              : ephm_pkg::THRESHOLD_W;
  localparam int POS_W  = 12;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic [ephm_pkg::THRESHOLD_W-1:0] threshold;
  logic [ephm_pkg::LIMIT_W-1:0]     column_limit;

  logic [ADDR_W-1:0]               clr_addr;
  logic [ADDR_W-1:0]               ev_addr;
  logic                            ev_ok;
  logic [ephm_pkg::WEIGHT_W-1:0]   w_eff;
  logic [ADDR_W-1:0]               row_base;
  logic [YY_W-1:0]                 ybase;
  logic                            row_ok;
  logic [LANE_W-1:0]               lane;
  logic [LANE_W-1:0]               lane_d;
  logic                            lane_ok_d;
  logic                            cap_d;
  logic [SCAN_LANES-1:0]           mask;
  logic [COUNT_BITS-1:0]           rd_data;

  logic [ADDR_W-1:0]     row_prod;
  logic [YY_W-1:0]       yy;
  logic                  lane_ok;
  logic [ADDR_W-1:0]     scan_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_en;
  logic                  hit;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] wr_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= ephm_pkg::THRESHOLD_RESET;
      column_limit <= ephm_pkg::COLUMN_LIMIT_RESET;
    end else if (write_en) begin
      case (reg_index)
        ephm_pkg::REG_THRESHOLD:    threshold <= write_data[ephm_pkg::THRESHOLD_W-1:0];
        ephm_pkg::REG_COLUMN_LIMIT: column_limit <= write_data[ephm_pkg::LIMIT_W-1:0];
        default:                    ;
      endcase
    end
  end

  assign row_prod = ADDR_W'(ADDR_W'(x) * ADDR_W'(SENSOR_HEIGHT));

  // latch the word on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_addr  <= ADDR_W'(row_prod + ADDR_W'(y));
      ev_ok    <= (POS_W'(x) < POS_W'(SENSOR_WIDTH)) && (POS_W'(y) < POS_W'(SENSOR_HEIGHT));
      w_eff    <= (weight == '0) ? ephm_pkg::WEIGHT_W'(1) : weight;
      row_base <= row_prod;
      ybase    <= YY_W'(YY_W'(y_block) * YY_W'(SCAN_LANES));
      row_ok   <= POS_W'(x) < POS_W'(SENSOR_WIDTH);
      row      <= x;
      block    <= y_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= ADDR_W'(clr_addr + ADDR_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane  <= '0;
      cap_d <= 1'b0;
    end else begin
      cap_d <= cmd.scan_read;
      if (cmd.load) begin
        lane <= '0;
      end else if (cmd.scan_read) begin
        lane <= LANE_W'(lane + LANE_W'(1));
      end
    end
  end

  assign yy        = YY_W'(ybase + YY_W'(lane));
  assign lane_ok   = row_ok && (POS_W'(yy) < POS_W'(SENSOR_HEIGHT))
                     && (POS_W'(yy) < POS_W'(column_limit));
  assign scan_addr = ADDR_W'(row_base + ADDR_W'(yy));

  assign rd_addr = cmd.scan_read ? scan_addr : ev_addr;
  assign rd_en   = (cmd.scan_read && lane_ok) || (cmd.ev_read && ev_ok);

  assign sum    = (COUNT_BITS+1)'(rd_data) + (COUNT_BITS+1)'(w_eff);
  assign wr_val = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr] <= '0;
    end else if (cmd.ev_write && ev_ok) begin
      mem[ev_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_read) begin
      lane_d    <= lane;
      lane_ok_d <= lane_ok;
    end
  end

  assign hit = CMP_W'(rd_data) > CMP_W'(threshold);

  // read data is registered, so it arrives in the cycle after its lane
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask <= '0;
    end else if (cap_d) begin
      mask[lane_d] <= lane_ok_d && hit;
    end
  end

  assign hot_mask = ephm_pkg::MASK_W'(mask);

  assign status.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign status.lane_last  = (lane == LANE_W'(SCAN_LANES - 1));

endmodule

// ----- rtl/event_pixel_hot_map.sv -----
`timescale 1ns / 1ps
// Per-pixel event counter map with a threshold scan.
// Command channel: a word (kind, x, y, y_block, weight) is taken at a clock edge with
// start high and busy low. kind selects an event (add weight, zero counts as one, to
// the saturating counter at x,y; off-sensor events are dropped) or a scan of row x.
// A scan returns one word (row, block, hot_mask) on the result ports, marked by done
// high for exactly one cycle; the receiver always takes it and cannot stall the block.
// An event steps through a read state and a write state before the next word can be
// taken: the counter memory read is registered, so each event is a read and a write in
// the cycle after it. A scan reads one lane a cycle, then passes through a drain state
// to the result state, where done rises, and the next word is taken after that.
// Reset: threshold and column_limit return to 100 and 185, and the counter memory is
// cleared by a pass over all SENSOR_WIDTH*SENSOR_HEIGHT entries (72960 by default), one
// entry a cycle, with busy high. Register writes are taken at any time, also during
// the clearing pass; write them only while no word is in flight.
module event_pixel_hot_map #(
  parameter int SENSOR_WIDTH  = 304,
  parameter int SENSOR_HEIGHT = 240,
  parameter int COUNT_BITS    = 16,
  parameter int SCAN_LANES    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [ephm_pkg::X_W-1:0]         x,
  input  logic [ephm_pkg::Y_W-1:0]         y,
  input  logic [ephm_pkg::BLOCK_W-1:0]     y_block,
  input  logic [ephm_pkg::WEIGHT_W-1:0]    weight,
  output logic                             done,
  output logic [ephm_pkg::X_W-1:0]         row,
  output logic [ephm_pkg::BLOCK_W-1:0]     block,
  output logic [ephm_pkg::MASK_W-1:0]      hot_mask,
  input  logic                             write_en,
  input  logic [ephm_pkg::CFG_INDEX_W-1:0] reg_index,
  input  logic [ephm_pkg::CFG_DATA_W-1:0]  write_data
);

  ephm_pkg::cmd_t    cmd;
  ephm_pkg::status_t status;

  ephm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ephm_dp #(
    .SENSOR_WIDTH  (SENSOR_WIDTH),
    .SENSOR_HEIGHT (SENSOR_HEIGHT),
    .COUNT_BITS    (COUNT_BITS),
    .SCAN_LANES    (SCAN_LANES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .x          (x),
    .y          (y),
    .y_block    (y_block),
    .weight     (weight),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .row        (row),
    .block      (block),
    .hot_mask   (hot_mask)
  );

endmodule

// ----- rtl/ephm_checker.sv -----
`timescale 1ns / 1ps
module ephm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done
);

  // a result only shows while the block is still holding off new words
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("busy did not rise after accept");

  a_event_silent: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && (kind == ephm_pkg::KIND_EVENT)) |=> !done ##1 !done)
    else $error("event produced a result");

endmodule

bind event_pixel_hot_map ephm_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .kind  (kind),
  .done  (done)
);
